[design/cdr_pkg.sv]
// Shared types, constants and helper functions for the cepstral delta
// regression block. No dependencies; every other design file imports it.
package cdr_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_COEFFS_DEF      = 16;
  localparam int MAX_HALF_WINDOW_DEF = 3;
  localparam int MAX_FRAMES_DEF      = 1024;

  // Field and register widths.
  localparam int COEFF_W     = 16;
  localparam int FRAME_IDX_W = 10;
  localparam int COEFF_IDX_W = 4;
  localparam int HW_REG_W    = 2;
  localparam int CC_REG_W    = 5;
  localparam int CC_W        = 6;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [HW_REG_W-1:0] HALF_WINDOW_RESET = 2'd2;
  localparam logic [CC_REG_W-1:0] COEFF_COUNT_RESET = 5'd13;

  // Regression arithmetic, sized for a half window of at most three.
  localparam int NUM_W       = 21;
  localparam int DIVX_W      = 20;
  localparam int Q_W         = DIVX_W + 1;
  localparam int DEN_W       = 5;
  localparam int RECIP_SHIFT = DIVX_W;

  localparam int DEN_1 = 2;
  localparam int DEN_2 = 10;
  localparam int DEN_3 = 28;
  localparam int RECIP_1 = (1 << RECIP_SHIFT) / DEN_1;
  localparam int RECIP_2 = (1 << RECIP_SHIFT) / DEN_2;
  localparam int RECIP_3 = (1 << RECIP_SHIFT) / DEN_3;

  localparam logic [Q_W-1:0]     POS_LIMIT = Q_W'(32767);
  localparam logic [Q_W-1:0]     NEG_LIMIT = Q_W'(32768);
  localparam logic [COEFF_W-1:0] SAT_POS   = 16'h7FFF;
  localparam logic [COEFF_W-1:0] SAT_NEG   = 16'h8000;

  typedef enum logic {
    REG_HALF_WINDOW,
    REG_COEFF_COUNT
  } cdr_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAP,
    S_TAP_END,
    S_DIV_ADD,
    S_DIV_MUL,
    S_DIV_QD,
    S_DIV_FIX,
    S_PASS_RD,
    S_PASS_LD,
    S_EMIT_RES,
    S_FLUSH_RD,
    S_FLUSH_LD,
    S_EMIT_FLUSH
  } cdr_state_t;

  typedef struct packed {
    logic capture;
    logic tap_rd;
    logic pass_rd;
    logic flush_rd;
    logic load_ram;
    logic div_add;
    logic div_mul;
    logic div_qd;
    logic div_fix;
    logic emit_res;
    logic emit_flush;
  } cdr_cmd_t;

  typedef struct packed {
    logic full_win;
    logic pass_thru;
    logic flush_req;
    logic flush_pend;
    logic tap_last;
    logic flush_done;
    logic out_free;
  } cdr_stat_t;

  // Sum of m squared over -W..W.
  function automatic logic [DEN_W-1:0] den_of(logic [HW_REG_W-1:0] w);
    logic [DEN_W-1:0] d;
    unique case (w)
      2'd2:    d = DEN_W'(DEN_2);
      2'd3:    d = DEN_W'(DEN_3);
      default: d = DEN_W'(DEN_1);
    endcase
    return d;
  endfunction

  // Reciprocal of den_of(w), scaled by 2**RECIP_SHIFT and rounded down.
  function automatic logic [DIVX_W-1:0] recip_of(logic [HW_REG_W-1:0] w);
    logic [DIVX_W-1:0] r;
    unique case (w)
      2'd2:    r = DIVX_W'(RECIP_2);
      2'd3:    r = DIVX_W'(RECIP_3);
      default: r = DIVX_W'(RECIP_1);
    endcase
    return r;
  endfunction

endpackage

[design/cdr_regs.sv]
// Configuration register file: half window and coefficient count behind
// an APB-style port. Depends on cdr_pkg.
module cdr_regs import cdr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [HW_REG_W-1:0]   half_window,
  output logic [CC_REG_W-1:0]   coeff_count
);

  cdr_reg_t sel;

  assign pready = 1'b1;
  assign sel    = cdr_reg_t'(paddr[CFG_ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= HALF_WINDOW_RESET;
      coeff_count <= COEFF_COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (sel)
        REG_HALF_WINDOW: half_window <= pwdata[HW_REG_W-1:0];
        REG_COEFF_COUNT: coeff_count <= pwdata[CC_REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_HALF_WINDOW: prdata = {{(CFG_DATA_W-HW_REG_W){1'b0}}, half_window};
      REG_COEFF_COUNT: prdata = {{(CFG_DATA_W-CC_REG_W){1'b0}}, coeff_count};
    endcase
  end

endmodule

[design/cdr_ctrl.sv]
// Sequencer for the delta regression: steps each item through window reads,
// the reciprocal divide, pass-through reads and the end-of-set flush.
// Depends on cdr_pkg.
module cdr_ctrl import cdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  cdr_stat_t stat,
  output logic      in_ready,
  output cdr_cmd_t  cmd
);

  cdr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.full_win) begin
            state_next = S_TAP;
          end else if (stat.pass_thru) begin
            state_next = S_PASS_RD;
          end else if (stat.flush_req) begin
            state_next = S_FLUSH_RD;
          end
        end
      end
      S_TAP: begin
        if (stat.tap_last) begin
          state_next = S_TAP_END;
        end
      end
      S_TAP_END:  state_next = S_DIV_ADD;
      S_DIV_ADD:  state_next = S_DIV_MUL;
      S_DIV_MUL:  state_next = S_DIV_QD;
      S_DIV_QD:   state_next = S_DIV_FIX;
      S_DIV_FIX:  state_next = S_EMIT_RES;
      S_PASS_RD:  state_next = S_PASS_LD;
      S_PASS_LD:  state_next = S_EMIT_RES;
      S_EMIT_RES: begin
        if (stat.out_free) begin
          state_next = stat.flush_pend ? S_FLUSH_RD : S_IDLE;
        end
      end
      S_FLUSH_RD: state_next = S_FLUSH_LD;
      S_FLUSH_LD: state_next = S_EMIT_FLUSH;
      S_EMIT_FLUSH: begin
        if (stat.out_free) begin
          state_next = stat.flush_done ? S_IDLE : S_FLUSH_RD;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_TAP:        cmd.tap_rd     = 1'b1;
      S_DIV_ADD:    cmd.div_add    = 1'b1;
      S_DIV_MUL:    cmd.div_mul    = 1'b1;
      S_DIV_QD:     cmd.div_qd     = 1'b1;
      S_DIV_FIX:    cmd.div_fix    = 1'b1;
      S_PASS_RD:    cmd.pass_rd    = 1'b1;
      S_PASS_LD:    cmd.load_ram   = 1'b1;
      S_EMIT_RES:   cmd.emit_res   = stat.out_free;
      S_FLUSH_RD:   cmd.flush_rd   = 1'b1;
      S_FLUSH_LD:   cmd.load_ram   = 1'b1;
      S_EMIT_FLUSH: cmd.emit_flush = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[design/cdr_dpath.sv]
// Datapath of the delta regression: frame ring memory, frame and coefficient
// counters, multiply-accumulate, reciprocal divide and the result register.
// Depends on cdr_pkg; driven by cdr_ctrl.
module cdr_dpath import cdr_pkg::*; #(
  parameter int MAX_COEFFS      = MAX_COEFFS_DEF,
  parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
  parameter int MAX_FRAMES      = MAX_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [HW_REG_W-1:0]    half_window,
  input  logic [CC_REG_W-1:0]    coeff_count,
  input  logic [COEFF_W-1:0]     in_coeff,
  input  logic                   in_last,
  input  cdr_cmd_t               cmd,
  output cdr_stat_t              stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [COEFF_W-1:0]     out_delta,
  output logic [FRAME_IDX_W-1:0] out_frame,
  output logic [COEFF_IDX_W-1:0] out_coeff,
  output logic                   out_last
);

  localparam int RING_FRAMES = 2 * MAX_HALF_WINDOW + 1;
  localparam int RING_DEPTH  = RING_FRAMES * MAX_COEFFS;
  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = $clog2(RING_FRAMES);
  localparam int CW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int FW = $clog2(MAX_FRAMES);

  // Slot that lies `back` frames behind `hd` in a ring of `sz` frames.
  function automatic logic [SW-1:0] back_slot(logic [SW-1:0] hd, logic [SW-1:0] sz,
                                               logic [SW-1:0] bk);
    logic [SW:0] t;
    t = {1'b0, hd} + {1'b0, sz} - {1'b0, bk};
    if (t >= {1'b0, sz}) begin
      t = t - {1'b0, sz};
    end
    return t[SW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_addr(logic [SW-1:0] slot, logic [CW-1:0] c);
    return AW'(slot) * AW'(MAX_COEFFS) + AW'(c);
  endfunction

  // Frame number `bk` frames before `f`, modulo MAX_FRAMES.
  function automatic logic [FW-1:0] frame_back(logic [FW-1:0] f, logic [HW_REG_W-1:0] bk);
    logic [FW:0] t;
    if (f >= FW'(bk)) begin
      t = (FW+1)'(f) - (FW+1)'(bk);
    end else begin
      t = (FW+1)'(f) + (FW+1)'(MAX_FRAMES) - (FW+1)'(bk);
    end
    return t[FW-1:0];
  endfunction

  // Counter state
  logic [SW-1:0] ring_head;
  logic [FW-1:0] frame_counter;
  logic [CW-1:0] coeff_counter;
  logic          wrapped;

  // Effective settings
  logic [HW_REG_W-1:0] w_eff;
  logic [SW-1:0]       s_eff;
  logic [SW-1:0]       head_eff;
  logic [CC_W-1:0]     cc_eff;
  logic                end_frame;
  logic [FW-1:0]       f_inc;
  logic [HW_REG_W-1:0] d_start;

  // Snapshot of the accepted item
  logic [SW-1:0]       head_q;
  logic [SW-1:0]       s_q;
  logic [HW_REG_W-1:0] w_q;
  logic [FW-1:0]       f_q;
  logic [CW-1:0]       i_q;
  logic [CC_W-1:0]     cc_q;
  logic                flush_pend;

  // Window taps and accumulator
  logic [SW-1:0]           tap_k;
  logic signed [3:0]       m_cur;
  logic signed [3:0]       rd_m;
  logic                    acc_pend;
  logic signed [NUM_W-1:0] acc;
  logic signed [19:0]      term;

  // Flush position
  logic [HW_REG_W-1:0] d_f;
  logic [CW-1:0]       c_f;
  logic                c_wrap;

  // Ring memory
  logic [COEFF_W-1:0] ring [RING_DEPTH];
  logic [COEFF_W-1:0] ram_q;
  logic               rd_en;
  logic [SW-1:0]      rd_back;
  logic [CW-1:0]      rd_c;
  logic [AW-1:0]      rd_addr;

  // Divider
  logic [DEN_W-1:0]    den;
  logic [NUM_W-1:0]    acc_mag;
  logic                neg_q;
  logic [DIVX_W-1:0]   div_x;
  logic [2*DIVX_W-1:0] prod;
  logic [DIVX_W-1:0]   q0;
  logic [DIVX_W-1:0]   qd;
  logic [DIVX_W-1:0]   rem;
  logic [Q_W-1:0]      q;
  logic [COEFF_W-1:0]  res;

  // Result fields
  logic [FW-1:0]                 fo;
  logic [FW+FRAME_IDX_W-1:0]     fo_wide;
  logic [CW-1:0]                 co;
  logic [CW+COEFF_IDX_W-1:0]     co_wide;

  // Settings as they act: zero means one, large values clamp.
  always_comb begin
    if (half_window == '0) begin
      w_eff = 2'd1;
    end else if (half_window > HW_REG_W'(MAX_HALF_WINDOW)) begin
      w_eff = HW_REG_W'(MAX_HALF_WINDOW);
    end else begin
      w_eff = half_window;
    end
    if (coeff_count == '0) begin
      cc_eff = CC_W'(1);
    end else if ({1'b0, coeff_count} > CC_W'(MAX_COEFFS)) begin
      cc_eff = CC_W'(MAX_COEFFS);
    end else begin
      cc_eff = {1'b0, coeff_count};
    end
  end

  assign s_eff = SW'({w_eff, 1'b1});

  // The head pointer may exceed the ring after the window was narrowed.
  always_comb begin
    head_eff = ring_head;
    if (head_eff >= s_eff) begin
      head_eff = head_eff - s_eff;
    end
    if (head_eff >= s_eff) begin
      head_eff = head_eff - s_eff;
    end
  end

  assign end_frame = (CC_W'(coeff_counter) + CC_W'(1)) >= cc_eff;
  assign f_inc = (frame_counter == FW'(MAX_FRAMES - 1)) ? '0 : frame_counter + FW'(1);

  always_comb begin
    d_start = w_eff - 2'd1;
    if (!wrapped && (frame_counter < FW'(d_start))) begin
      d_start = frame_counter[HW_REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head     <= '0;
      frame_counter <= '0;
      coeff_counter <= '0;
      wrapped       <= 1'b0;
      flush_pend    <= 1'b0;
    end else if (cmd.capture) begin
      flush_pend <= end_frame && in_last;
      if (end_frame && in_last) begin
        ring_head     <= '0;
        frame_counter <= '0;
        coeff_counter <= '0;
        wrapped       <= 1'b0;
      end else if (end_frame) begin
        coeff_counter <= '0;
        ring_head     <= (head_eff == s_eff - SW'(1)) ? '0 : head_eff + SW'(1);
        frame_counter <= f_inc;
        if (f_inc == '0) begin
          wrapped <= 1'b1;
        end
      end else begin
        coeff_counter <= coeff_counter + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      head_q <= head_eff;
      s_q    <= s_eff;
      w_q    <= w_eff;
      f_q    <= frame_counter;
      i_q    <= coeff_counter;
      cc_q   <= cc_eff;
    end
  end

  assign stat.full_win   = wrapped || (frame_counter >= FW'({w_eff, 1'b0}));
  assign stat.pass_thru  = frame_counter >= FW'(w_eff);
  assign stat.flush_req  = end_frame && in_last;
  assign stat.flush_pend = flush_pend;
  assign stat.tap_last   = (SW+1)'(tap_k) == (SW+1)'({w_q, 1'b0});
  assign stat.flush_done = (d_f == '0) && c_wrap;
  assign stat.out_free   = !out_valid || out_ready;

  // Tap k reads the frame k behind the newest one; its weight is W - k.
  assign m_cur = $signed({2'b00, w_q}) - $signed(4'(tap_k));
  assign term  = 20'(rd_m) * 20'($signed(ram_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_k    <= '0;
      acc_pend <= 1'b0;
    end else if (cmd.capture) begin
      tap_k    <= '0;
      acc_pend <= 1'b0;
    end else begin
      acc_pend <= cmd.tap_rd;
      if (cmd.tap_rd) begin
        tap_k <= tap_k + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= '0;
    end else if (acc_pend) begin
      acc <= acc + NUM_W'(term);
    end
    if (cmd.tap_rd) begin
      rd_m <= m_cur;
    end
  end

  // Flush walks frames from d_start down to the newest, all coefficients each.
  assign c_wrap = (CC_W'(c_f) + CC_W'(1)) == cc_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_f <= '0;
      c_f <= '0;
    end else if (cmd.capture) begin
      d_f <= d_start;
      c_f <= '0;
    end else if (cmd.emit_flush) begin
      if (c_wrap) begin
        c_f <= '0;
        d_f <= d_f - 2'd1;
      end else begin
        c_f <= c_f + CW'(1);
      end
    end
  end

  // Ring memory: written on capture, one registered read port.
  assign rd_en = cmd.tap_rd || cmd.pass_rd || cmd.flush_rd;

  always_comb begin
    if (cmd.flush_rd) begin
      rd_back = SW'(d_f);
      rd_c    = c_f;
    end else if (cmd.tap_rd) begin
      rd_back = tap_k;
      rd_c    = i_q;
    end else begin
      rd_back = SW'(w_q);
      rd_c    = i_q;
    end
  end

  assign rd_addr = ring_addr(back_slot(head_q, s_q, rd_back), rd_c);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ring[ring_addr(head_eff, coeff_counter)] <= in_coeff;
    end
    if (rd_en) begin
      ram_q <= ring[rd_addr];
    end
  end

  // Rounded divide by the constant denominator: add half, multiply by the
  // reciprocal, then one correction step on the remainder.
  assign den     = den_of(w_q);
  assign acc_mag = acc[NUM_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
  assign rem     = div_x - qd;
  assign q       = {1'b0, q0} + Q_W'(rem >= DIVX_W'(den));

  always_ff @(posedge clk) begin
    if (cmd.div_add) begin
      neg_q <= acc[NUM_W-1];
      div_x <= acc_mag[DIVX_W-1:0] + DIVX_W'(den[DEN_W-1:1]);
    end
    if (cmd.div_mul) begin
      prod <= (2*DIVX_W)'(div_x) * (2*DIVX_W)'(recip_of(w_q));
    end
    if (cmd.div_qd) begin
      q0 <= prod[2*DIVX_W-1:DIVX_W];
      qd <= prod[2*DIVX_W-1:DIVX_W] * DIVX_W'(den);
    end
    if (cmd.div_fix) begin
      if (neg_q) begin
        res <= (q > NEG_LIMIT) ? SAT_NEG : COEFF_W'(Q_W'(0) - q);
      end else begin
        res <= (q > POS_LIMIT) ? SAT_POS : q[COEFF_W-1:0];
      end
    end else if (cmd.load_ram) begin
      res <= ram_q;
    end
  end

  // Result register
  assign fo      = frame_back(f_q, cmd.emit_flush ? d_f : w_q);
  assign fo_wide = {{FRAME_IDX_W{1'b0}}, fo};
  assign co      = cmd.emit_flush ? c_f : i_q;
  assign co_wide = {{COEFF_IDX_W{1'b0}}, co};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_res || cmd.emit_flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_res || cmd.emit_flush) begin
      out_delta <= res;
      out_frame <= fo_wide[FRAME_IDX_W-1:0];
      out_coeff <= co_wide[COEFF_IDX_W-1:0];
      out_last  <= cmd.emit_flush && (d_f == '0) && c_wrap;
    end
  end

endmodule

[design/cepstral_delta_regression.sv]
// Top level of the cepstral delta regression block: configuration registers,
// sequencer and datapath. Depends on cdr_pkg, cdr_regs, cdr_ctrl, cdr_dpath.
//
// Usage. Cepstral coefficients enter on the s_ stream one item per
// coefficient, frame-major, coeff_count items to a frame; s_tlast marks the
// final coefficient of the final frame of a set. Results leave on the m_
// stream: the regression delta of the frame W behind the newest one, or the
// unchanged value for the first W frames, and after the last item of a set
// the final W frames pass through, with m_tlast on the set's final result.
// half_window (W) and coeff_count are written over the APB port while the
// block is idle.
//
// Timing. A coefficient whose frame has a full window reads the 2W+1 ring
// entries one per cycle through the single ring read port, then runs a
// four-step reciprocal divide before its result is loaded for output; no
// new item is taken until the sequencer is back in idle. A pass-through
// result and each flushed result take a ring read and a result load, and an
// item with no result returns straight to idle. The output register frees
// the input side: a new item is taken while a result still waits, and a
// stalled receiver only holds the sequencer when the next result is ready to
// go. Reset clears the counters, empties the output register and restores
// W = 2 and coeff_count = 13; the ring needs no clearing since every entry
// read is written first.
module cepstral_delta_regression import cdr_pkg::*; #(
  parameter int MAX_COEFFS      = MAX_COEFFS_DEF,
  parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
  parameter int MAX_FRAMES      = MAX_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // Coefficient input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] coeff_value
  input  logic                  s_tlast,   // end_of_set
  // Result output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [15:0] delta_value, [25:16] frame_index,
                                           // [29:26] coeff_index, [31:30] zero
  output logic                  m_tlast    // last_result
);

  logic [HW_REG_W-1:0]    half_window;
  logic [CC_REG_W-1:0]    coeff_count;
  cdr_cmd_t               cmd;
  cdr_stat_t              stat;
  logic [COEFF_W-1:0]     delta_value;
  logic [FRAME_IDX_W-1:0] frame_index;
  logic [COEFF_IDX_W-1:0] coeff_index;

  cdr_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .half_window (half_window),
    .coeff_count (coeff_count)
  );

  cdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  cdr_dpath #(
    .MAX_COEFFS      (MAX_COEFFS),
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .MAX_FRAMES      (MAX_FRAMES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .half_window (half_window),
    .coeff_count (coeff_count),
    .in_coeff    (s_tdata),
    .in_last     (s_tlast),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_delta   (delta_value),
    .out_frame   (frame_index),
    .out_coeff   (coeff_index),
    .out_last    (m_tlast)
  );

  assign m_tdata = {2'b00, coeff_index, frame_index, delta_value};

  // A new result is loaded only when the output register is free to take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_res || cmd.emit_flush) |-> stat.out_free)
    else $error("result loaded over one still waiting");

  // After reset the output is empty and the input side is open.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("reset did not empty the block");

  // An item with a full window keeps the input closed while it is worked on.
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && stat.full_win) |=> !s_tready)
    else $error("input taken during a regression");

  // Captures happen only on an input handshake, never during ring reads.
  a_capture_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (s_tvalid && s_tready && !cmd.tap_rd && !cmd.flush_rd && !cmd.pass_rd))
    else $error("capture outside an input handshake");

endmodule

[sim/tb_cepstral_delta_regression.sv]
// Self-checking testbench for the cepstral delta regression block: streams
// coefficient sets, checks every result against an in-bench predictor.
// Depends on cdr_pkg and the cepstral_delta_regression top level.
module tb_cepstral_delta_regression;
  import cdr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Ring geometry and frame numbering follow the block's default parameters.
  localparam int MAXC      = MAX_COEFFS_DEF;
  localparam int MAXW      = MAX_HALF_WINDOW_DEF;
  localparam int NFR       = MAX_FRAMES_DEF;
  localparam int RING_SLOTS = 2 * MAXW + 1;
  // Cycles allowed for the block to finish an item that produces no result.
  localparam int SETTLE    = 40;
  // Upper bound on the items of one random set, so the run stays short.
  localparam int SET_ITEMS_MAX = 48;

  // One expected result, in the order of the output fields.
  typedef struct packed {
    logic [COEFF_W-1:0]     delta;
    logic [FRAME_IDX_W-1:0] frame;
    logic [COEFF_IDX_W-1:0] coeff;
    logic                   last;
  } delta_res_t;

  // Directed stimulus: either a register write or one coefficient item. Where
  // the delta of the first result an item causes is obvious, it is typed in.
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    cdr_reg_t           reg_idx;
    logic [4:0]         reg_val;
    logic [COEFF_W-1:0] coeff;
    logic               last;
    logic               typed;
    logic [COEFF_W-1:0] want;
  } dir_row_t;

  localparam int DIR_ROWS = 31;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // W = 1, one coefficient per frame: pass-through of frame 0, then the
    // regression at both saturation limits and a plain rounding case.
    '{ROW_REG,  REG_HALF_WINDOW, 5'd1, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_REG,  REG_COEFF_COUNT, 5'd1, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h8000, 1'b0, 1'b1, 16'h7FFF},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h8000, 1'b0, 1'b1, 16'h8000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h0001, 1'b1, 1'b1, 16'h4001},
    // Ties of the rounding go away from zero on both signs.
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h0000, 1'b0, 1'b1, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h0001, 1'b0, 1'b1, 16'h0001},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
    // A set shorter than the window passes through entirely; the end flag on
    // a coefficient that does not close a frame must be ignored.
    '{ROW_REG,  REG_HALF_WINDOW, 5'd3, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_REG,  REG_COEFF_COUNT, 5'd2, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h1234, 1'b1, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h00FF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h5A5A, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'hA5A5, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h0F0F, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'hF0F0, 1'b1, 1'b1, 16'h1234},
    // Zero in either register behaves as one.
    '{ROW_REG,  REG_HALF_WINDOW, 5'd0, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_REG,  REG_COEFF_COUNT, 5'd0, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h0100, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h0300, 1'b0, 1'b1, 16'h0100},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h0200, 1'b1, 1'b1, 16'h0080},
    // W = 2 with a full window for the last two frames.
    '{ROW_REG,  REG_HALF_WINDOW, 5'd2, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h4000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'hC000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h3FFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h8001, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, REG_HALF_WINDOW, 5'd0, 16'h0000, 1'b1, 1'b0, 16'h0000}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;   // [15:0] coeff_value
  logic                  s_tlast;   // end_of_set
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [31:0]           m_tdata;   // [15:0] delta_value, [25:16] frame_index,
                                    // [29:26] coeff_index, [31:30] zero
  logic                  m_tlast;   // last_result

  cepstral_delta_regression u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Predictor state: a private copy of the registers, the frame ring and the
  // position counters, kept in step with every accepted item.
  logic [HW_REG_W-1:0]    hw_reg = HALF_WINDOW_RESET;
  logic [CC_REG_W-1:0]    cc_reg = COEFF_COUNT_RESET;
  logic signed [15:0]     win_ring [RING_SLOTS*MAXC];
  logic [FRAME_IDX_W-1:0] frm_cnt = '0;
  logic [COEFF_IDX_W-1:0] cof_cnt = '0;
  int                     ring_head_slot = 0;
  bit                     frm_wrapped = 1'b0;

  delta_res_t pending_deltas [$];
  int         err_cnt = 0;
  int         items_sent = 0;
  bit         idle_on = 1'b1;
  int         rdy_stall = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous upper bound on the run; a hung block lands here.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Effective half window and frame length: zero acts as one, and values
  // above the block's maximum are clipped.
  function automatic int eff_half();
    if (hw_reg == 0) return 1;
    return (int'(hw_reg) > MAXW) ? MAXW : int'(hw_reg);
  endfunction

  function automatic int eff_coeffs();
    if (cc_reg == 0) return 1;
    return (int'(cc_reg) > MAXC) ? MAXC : int'(cc_reg);
  endfunction

  // Quotient rounded to nearest, ties away from zero, saturated to 16 bits.
  function automatic logic [15:0] round_sat(input int num, input int den);
    int unsigned mag;
    int unsigned q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    if (num < 0) return (q > 32768) ? SAT_NEG : 16'(-int'(q));
    return (q > 32767) ? SAT_POS : 16'(q);
  endfunction

  // Append one expected result at the back of the queue.
  task automatic add_expect(input logic [15:0] value, input int fr, input int co,
                            input logic l);
    delta_res_t r;
    r.delta = value;
    r.frame = FRAME_IDX_W'(fr);
    r.coeff = COEFF_IDX_W'(co);
    r.last  = l;
    pending_deltas.insert(pending_deltas.size(), r);
  endtask

  // Advance the predictor by one accepted coefficient and queue the results
  // it causes: the center frame W behind the newest one, then, on the item
  // that ends a set, the final W frames in order.
  task automatic predict_deltas(input logic [15:0] value, input logic eos);
    int w;
    int cc;
    int s;
    int head;
    int ci;
    int fi;
    int num;
    int den;
    logic [15:0] res;
    w = eff_half();
    cc = eff_coeffs();
    s = 2 * w + 1;
    head = ring_head_slot % s;
    ci = int'(cof_cnt);
    fi = int'(frm_cnt);
    win_ring[head*MAXC + ci] = value;

    if (frm_wrapped || fi >= w) begin
      if (frm_wrapped || fi >= 2 * w) begin
        num = 0;
        den = 0;
        for (int m = -w; m <= w; m++) begin
          num += m * int'(win_ring[((head + s - (w - m)) % s)*MAXC + ci]);
          den += m * m;
        end
        res = round_sat(num, den);
      end else begin
        // Leading edge of the set: the center frame passes unchanged.
        res = win_ring[((head + s - w) % s)*MAXC + ci];
      end
      add_expect(res, (fi + NFR - w) % NFR, ci, 1'b0);
    end

    if (ci + 1 >= cc && eos) begin
      // Trailing edge: flush the newest W frames, oldest first.
      for (int d = w - 1; d >= 0; d--) begin
        if (!(frm_wrapped || fi >= d)) continue;
        for (int c = 0; c < cc; c++)
          add_expect(win_ring[((head + s - d) % s)*MAXC + c], (fi + NFR - d) % NFR, c,
                     (d == 0 && c + 1 == cc));
      end
      frm_cnt = '0;
      cof_cnt = '0;
      ring_head_slot = 0;
      frm_wrapped = 1'b0;
    end else if (ci + 1 >= cc) begin
      cof_cnt = '0;
      ring_head_slot = (head + 1) % s;
      frm_cnt = FRAME_IDX_W'((fi + 1) % NFR);
      if (frm_cnt == 0) frm_wrapped = 1'b1;
    end else begin
      cof_cnt = cof_cnt + 1'b1;
    end
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_xfer(input logic wr, input cdr_reg_t idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = CFG_ADDR_W'(4 * int'(idx));
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Write a register, mirror it into the predictor, and read it back.
  task automatic reg_write(input cdr_reg_t idx, input logic [4:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    apb_xfer(1'b1, idx, {27'b0, val}, rd);
    if (idx == REG_HALF_WINDOW) begin
      hw_reg = val[HW_REG_W-1:0];
      want = {30'b0, val[HW_REG_W-1:0]};
    end else begin
      cc_reg = val;
      want = {27'b0, val};
    end
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== want) report_mismatch("register readback", rd, want);
  endtask

  // Stop sending, then wait until every queued result has arrived and the
  // block has had time to finish items that produce nothing.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_deltas.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offer one item, with an occasional idle burst first. Valid stays high
  // from one item to the next when there is no burst.
  task automatic send_coeff(input logic [15:0] value, input logic last,
                            input logic typed, input logic [15:0] want);
    int gap;
    int first;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = value;
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
    first = pending_deltas.size();
    predict_deltas(value, last);
    if (typed && pending_deltas.size() > first) pending_deltas[first].delta = want;
    items_sent++;
  endtask

  // Mostly random values, with the extremes and tiny values mixed in.
  function automatic logic [15:0] pick_coeff();
    unique case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Send a number of whole frames at the current frame length. The end flag
  // is set on the final coefficient when close is set; elsewhere it appears
  // now and then on coefficients that do not end a frame, where it is noise.
  task automatic send_set(input int frames, input bit close);
    int cc;
    logic l;
    cc = eff_coeffs();
    for (int fr = 0; fr < frames; fr++) begin
      for (int c = 0; c < cc; c++) begin
        l = 1'b0;
        if (close && fr == frames - 1 && c == cc - 1) l = 1'b1;
        else if (c != cc - 1 && $urandom_range(0, 9) == 0) l = 1'b1;
        send_coeff(pick_coeff(), l, 1'b0, '0);
      end
    end
  endtask

  // Random frame length register: mostly short frames, sometimes zero, a
  // longer frame of 5 to 16, or a value beyond the maximum.
  function automatic logic [4:0] pick_cc_reg();
    unique case ($urandom_range(0, 19))
      0:       return 5'd0;
      1:       return 5'($urandom_range(17, 31));
      2:       return 5'($urandom_range(5, 16));
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  // A complete random set: new registers, then a window-sized or longer set
  // most of the time, and a set shorter than the window otherwise. Long
  // frames shorten the set so that it stays within a few dozen items.
  task automatic random_set();
    int w;
    int cc;
    int frames;
    wait_idle();
    reg_write(REG_HALF_WINDOW, 5'($urandom_range(0, 3)));
    reg_write(REG_COEFF_COUNT, pick_cc_reg());
    w = eff_half();
    cc = eff_coeffs();
    if ($urandom_range(0, 3) == 0) frames = $urandom_range(1, 2 * w);
    else frames = $urandom_range(2 * w + 1, 2 * w + 6);
    while (frames > 1 && frames * cc > SET_ITEMS_MAX) frames--;
    send_set(frames, 1'b1);
  endtask

  // The receiver stalls in bursts of random length while idling is on.
  always @(negedge clk) begin
    if (rdy_stall > 0) begin
      rdy_stall--;
      m_tready = 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rdy_stall = $urandom_range(1, 7) - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    delta_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_deltas.size() == 0) begin
        report_mismatch("result with nothing pending", m_tdata, '0);
      end else begin
        want = pending_deltas.pop_front();
        if (m_tdata[15:0] !== want.delta)
          report_mismatch("delta_value", 32'(m_tdata[15:0]), 32'(want.delta));
        if (m_tdata[25:16] !== want.frame)
          report_mismatch("frame_index", 32'(m_tdata[25:16]), 32'(want.frame));
        if (m_tdata[29:26] !== want.coeff)
          report_mismatch("coeff_index", 32'(m_tdata[29:26]), 32'(want.coeff));
        if (m_tdata[31:30] !== 2'b00)
          report_mismatch("tdata padding", 32'(m_tdata[31:30]), '0);
        if (m_tlast !== want.last)
          report_mismatch("last_result", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    logic [31:0] rd;
    int start_items;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    foreach (win_ring[k]) win_ring[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Registers come out of reset at W = 2 and 13 coefficients per frame.
    apb_xfer(1'b0, REG_HALF_WINDOW, '0, rd);
    if (rd !== 32'(HALF_WINDOW_RESET)) report_mismatch("half_window after reset", rd, 32'd2);
    apb_xfer(1'b0, REG_COEFF_COUNT, '0, rd);
    if (rd !== 32'(COEFF_COUNT_RESET)) report_mismatch("coeff_count after reset", rd, 32'd13);

    // Directed part. Register rows wait for the block to drain first.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_REG) begin
        wait_idle();
        reg_write(DIR_TABLE[r].reg_idx, DIR_TABLE[r].reg_val);
      end else begin
        send_coeff(DIR_TABLE[r].coeff, DIR_TABLE[r].last, DIR_TABLE[r].typed,
                   DIR_TABLE[r].want);
      end
    end

    // The window narrowed in the middle of a set, at a frame boundary, once
    // the block has drained: the head slot is folded into the smaller ring,
    // and every entry the narrower window reads was written by this set.
    wait_idle();
    reg_write(REG_HALF_WINDOW, 5'd3);
    reg_write(REG_COEFF_COUNT, 5'd2);
    send_set(5, 1'b0);
    wait_idle();
    reg_write(REG_HALF_WINDOW, 5'd1);
    send_set(3, 1'b1);

    // Random sets with random registers.
    start_items = items_sent;
    while (items_sent - start_items < 50) random_set();

    // Closing stretch at full rate on both sides.
    wait_idle();
    idle_on = 1'b0;
    start_items = items_sent;
    while (items_sent - start_items < 15) random_set();

    wait_idle();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
